// ===== hdl/smcm_pkg.sv =====
// Shared types and constants of the serpentine matrix channel mapper.
// No dependencies; every other file of the block imports this package.
package smcm_pkg;

    // field widths
    localparam int CoordW   = 12;
    localparam int StringsW = 10;
    localparam int StrandsW = 8;
    localparam int NodesW   = 12;
    localparam int ChanW    = 24;
    localparam int AddrW    = 25;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    // derived datapath widths
    localparam int NstrW      = StringsW + StrandsW;   // strand count of the matrix
    localparam int StrandW    = NstrW + 1;             // signed strand index
    localparam int AbsW       = NstrW;                 // magnitude of the strand index
    localparam int RecipShift = AbsW;                  // reciprocal scale 2**RecipShift
    localparam int DivW       = RecipShift + 1;        // divider numerator and quotient
    localparam int DivCntW    = $clog2(DivW + 1);
    localparam int RemW       = StrandsW + 1;          // remainder estimate, below 2*s
    localparam int AlongW     = NodesW + 1;            // signed position along a strand
    localparam int SumW       = StrandW + AlongW;      // signed pixel offset in nodes
    localparam int OffW       = SumW + 2;              // signed offset in channels
    localparam int ProdNsW    = NodesW + StringsW;     // nodes * strings
    localparam int SpanW      = ProdNsW + 2;           // channel span of the matrix

    localparam logic [DivW-1:0] RecipNum = {1'b1, {RecipShift{1'b0}}};

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_ORIENTATION   = 3'd0,
        REG_START_CORNER  = 3'd1,
        REG_STRING_COUNT  = 3'd2,
        REG_STRANDS       = 3'd3,
        REG_NODES         = 3'd4,
        REG_START_CHANNEL = 3'd5
    } cfg_index_t;

    // first pixel corner
    typedef enum logic [1:0] {
        CORNER_BL = 2'd0,
        CORNER_BR = 2'd1,
        CORNER_TL = 2'd2,
        CORNER_TR = 2'd3
    } corner_t;

    // reset values
    localparam logic                ResetOrientation = 1'b0;
    localparam corner_t             ResetCorner      = CORNER_BL;
    localparam logic [StringsW-1:0] ResetStrings     = 10'd1;
    localparam logic [StrandsW-1:0] ResetStrands     = 8'd1;
    localparam logic [NodesW-1:0]   ResetNodes       = 12'd50;
    localparam logic [ChanW-1:0]    ResetStart       = 24'd1;

    // settled configuration handed to the item pipeline
    typedef struct packed {
        logic                orientation;   // 1 vertical strands
        corner_t             corner;
        logic [StrandsW-1:0] strands;       // strands per string, zero taken as one
        logic [NstrW-1:0]    strand_count;  // strings * strands
        logic [NodesW-1:0]   strand_len;    // nodes / strands
        logic [DivW-1:0]     recip;         // floor(2**RecipShift / strands)
        logic [SpanW-1:0]    span;          // 3 * nodes * strings
        logic [ChanW-1:0]    start;
    } map_cfg_t;

endpackage

// ===== hdl/smcm_if.sv =====
// Handshake channels of the mapper: pixel coordinates in, channel addresses out.
// Depends on smcm_pkg for the field widths.
interface smcm_coord_if import smcm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface smcm_result_if import smcm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AddrW-1:0] channel_address;
    logic             out_of_range;

    modport source (output valid, output channel_address, output out_of_range, input ready);
    modport sink   (input valid, input channel_address, input out_of_range, output ready);
endinterface

// ===== hdl/serpentine_matrix_channel_map_core.sv =====
// Serpentine matrix channel mapper: items pass the smcm_pipe stages to a result.
// Throughput one item per cycle unless input is held off or the output stalls;
// a stalled output holds only the stages behind it. After reset, and after each write
// of string_count, strands_per_string or nodes_per_string, input is held off while
// both serial dividers recompute strand length and reciprocal (one quotient bit per
// cycle). Reset clears all valid bits and loads the register reset values.
module serpentine_matrix_channel_map_core import smcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    smcm_coord_if.sink          coord,
    smcm_result_if.source       result
);

    map_cfg_t cfg;
    logic     cfg_busy;

    // registers and derived matrix geometry
    smcm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (cfg_busy)
    );

    // per-item address pipeline
    smcm_pipe u_pipe
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .hold   (cfg_busy),
        .cfg    (cfg),
        .coord  (coord),
        .result (result)
    );

endmodule

// ===== hdl/smcm_div.sv =====
// Restoring divider, one quotient bit per cycle, for config-derived values.
// Depends on smcm_pkg for widths.
module smcm_div import smcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DivW-1:0]     num,
    input  logic [StrandsW-1:0] den,
    output logic                busy,
    output logic [DivW-1:0]     quo
);

    logic                busy_reg, busy_next;
    logic [DivCntW-1:0]  cnt_reg, cnt_next;
    logic [StrandsW-1:0] rem_reg, rem_next;
    logic [DivW-1:0]     quo_reg, quo_next;
    logic [StrandsW-1:0] den_reg, den_next;
    logic [StrandsW:0]   shifted;
    logic [StrandsW:0]   diff;
    logic                fits;

    // one shift and trial subtract per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DivW-1]};
        diff      = shifted - {1'b0, den_reg};
        fits      = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DivCntW'(DivW);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[StrandsW-1:0] : shifted[StrandsW-1:0];
            quo_next = {quo_reg[DivW-2:0], fits};
            cnt_next = cnt_reg - DivCntW'(1);
            if (cnt_reg == DivCntW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/smcm_cfg.sv =====
// Configuration registers and the values derived from them (matrix size,
// strand length, reciprocal of the strand count, channel span).
// Depends on smcm_pkg and smcm_div.
module smcm_cfg import smcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output map_cfg_t            cfg,
    output logic                busy
);

    logic                orient_reg, orient_next;
    corner_t             corner_reg, corner_next;
    logic [StringsW-1:0] strings_reg, strings_next;
    logic [StrandsW-1:0] strands_reg, strands_next;
    logic [NodesW-1:0]   nodes_reg, nodes_next;
    logic [ChanW-1:0]    start_reg, start_next;
    logic                kick_reg, kick_next;
    logic [NstrW-1:0]    nstr_reg;
    logic [SpanW-1:0]    span_reg;
    logic [StrandsW-1:0] strands_eff;
    logic [ProdNsW-1:0]  nodes_strings;
    logic                len_busy;
    logic                recip_busy;
    logic [DivW-1:0]     len_quo;
    logic [DivW-1:0]     recip_quo;

    // register writes; size registers restart the dividers
    always_comb
    begin
        orient_next  = orient_reg;
        corner_next  = corner_reg;
        strings_next = strings_reg;
        strands_next = strands_reg;
        nodes_next   = nodes_reg;
        start_next   = start_reg;
        kick_next    = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_ORIENTATION:   orient_next = cfg_data[0];
                REG_START_CORNER:  corner_next = corner_t'(cfg_data[1:0]);
                REG_STRING_COUNT:
                begin
                    strings_next = cfg_data[StringsW-1:0];
                    kick_next    = 1'b1;
                end
                REG_STRANDS:
                begin
                    strands_next = cfg_data[StrandsW-1:0];
                    kick_next    = 1'b1;
                end
                REG_NODES:
                begin
                    nodes_next = cfg_data[NodesW-1:0];
                    kick_next  = 1'b1;
                end
                REG_START_CHANNEL: start_next = cfg_data[ChanW-1:0];
                default:           kick_next  = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg  <= ResetOrientation;
            corner_reg  <= ResetCorner;
            strings_reg <= ResetStrings;
            strands_reg <= ResetStrands;
            nodes_reg   <= ResetNodes;
            start_reg   <= ResetStart;
            kick_reg    <= 1'b1;
        end
        else
        begin
            orient_reg  <= orient_next;
            corner_reg  <= corner_next;
            strings_reg <= strings_next;
            strands_reg <= strands_next;
            nodes_reg   <= nodes_next;
            start_reg   <= start_next;
            kick_reg    <= kick_next;
        end
    end

    // products, settled long before the dividers finish
    always_comb
    begin
        strands_eff   = (strands_reg == '0) ? StrandsW'(1) : strands_reg;
        nodes_strings = ProdNsW'(nodes_reg) * ProdNsW'(strings_reg);
    end

    always_ff @(posedge clk)
    begin
        nstr_reg <= NstrW'(strings_reg) * NstrW'(strands_eff);
        span_reg <= {nodes_strings, 1'b0} + SpanW'(nodes_strings);
    end

    // strand length nodes / s
    smcm_div u_len_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (kick_reg),
        .num   (DivW'(nodes_reg)),
        .den   (strands_eff),
        .busy  (len_busy),
        .quo   (len_quo)
    );

    // reciprocal 2**RecipShift / s
    smcm_div u_recip_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (kick_reg),
        .num   (RecipNum),
        .den   (strands_eff),
        .busy  (recip_busy),
        .quo   (recip_quo)
    );

    always_comb
    begin
        cfg.orientation  = orient_reg;
        cfg.corner       = corner_reg;
        cfg.strands      = strands_eff;
        cfg.strand_count = nstr_reg;
        cfg.strand_len   = len_quo[NodesW-1:0];
        cfg.recip        = recip_quo;
        cfg.span         = span_reg;
        cfg.start        = start_reg;
    end

    assign busy = kick_reg || len_busy || recip_busy;

endmodule

// ===== hdl/smcm_pipe.sv =====
// Five-stage item pipeline: strand index, products, remainder parity and
// direction, then offset, span check and output register.
// Depends on smcm_pkg and the channel interfaces.
module smcm_pipe import smcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 hold,
    input  map_cfg_t             cfg,
    smcm_coord_if.sink           coord,
    smcm_result_if.source        result
);

    // stage enables
    logic en1, en2, en3, en4, en5;
    logic take;

    // stage 1
    logic                     v1_reg;
    logic signed [StrandW-1:0] strand1_reg;
    logic [AbsW-1:0]          abs1_reg;
    logic                     neg1_reg;
    logic                     a0_1_reg;
    logic [CoordW-1:0]        b1_reg;
    logic signed [AlongW-1:0] rb1_reg;
    logic                     vert;
    logic                     rev;
    logic [CoordW-1:0]        a_in;
    logic [CoordW-1:0]        b_in;
    logic signed [StrandW-1:0] strand_in;
    logic [StrandW-1:0]       strand_neg;

    // stage 2
    logic                     v2_reg;
    logic [AbsW-1:0]          qest2_reg;
    logic signed [SumW-1:0]   psl2_reg;
    logic [AbsW-1:0]          abs2_reg;
    logic                     neg2_reg;
    logic                     a0_2_reg;
    logic [CoordW-1:0]        b2_reg;
    logic signed [AlongW-1:0] rb2_reg;
    logic [AbsW+DivW-1:0]     prod_q;
    logic signed [AlongW-1:0] len_s;
    logic signed [SumW-1:0]   prod_sl;

    // stage 3
    logic                     v3_reg;
    logic [AbsW-1:0]          qs3_reg;
    logic [AbsW-1:0]          abs3_reg;
    logic                     neg3_reg;
    logic                     a0_3_reg;
    logic signed [SumW-1:0]   sumf3_reg;
    logic signed [SumW-1:0]   sumr3_reg;
    logic [AbsW+StrandsW-1:0] prod_qs;

    // stage 4
    logic                     v4_reg;
    logic signed [SumW-1:0]   sum4_reg;
    logic [AbsW-1:0]          diff;
    logic [RemW-1:0]          rem_est;
    logic                     rem_odd;
    logic                     one_test;
    logic                     fwd;

    // stage 5
    logic                     v5_reg;
    logic [AddrW-1:0]         addr5_reg;
    logic                     oor5_reg;
    logic signed [OffW-1:0]   off;
    logic                     in_span;

    // ready ripples back through empty or moving stages
    always_comb
    begin
        en5         = !v5_reg || result.ready;
        en4         = !v4_reg || en5;
        en3         = !v3_reg || en4;
        en2         = !v2_reg || en3;
        en1         = !v1_reg || en2;
        coord.ready = en1 && !hold;
        take        = coord.valid && coord.ready;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= take;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // stage 1: strand index counted from the start corner
    always_comb
    begin
        vert = cfg.orientation;
        a_in = vert ? coord.pos_x : coord.pos_y;
        b_in = vert ? coord.pos_y : coord.pos_x;
        if (vert)
        begin
            rev = (cfg.corner == CORNER_BR) || (cfg.corner == CORNER_TR);
        end
        else
        begin
            rev = (cfg.corner == CORNER_TL) || (cfg.corner == CORNER_TR);
        end
        strand_in  = rev ? (StrandW'(cfg.strand_count) - StrandW'(a_in) - StrandW'(1))
                         : StrandW'(a_in);
        strand_neg = -strand_in;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            strand1_reg <= strand_in;
            neg1_reg    <= strand_in[StrandW-1];
            abs1_reg    <= strand_in[StrandW-1] ? strand_neg[AbsW-1:0]
                                                : strand_in[AbsW-1:0];
            a0_1_reg    <= a_in[0];
            b1_reg      <= b_in;
            rb1_reg     <= AlongW'(cfg.strand_len) - AlongW'(b_in) - AlongW'(1);
        end
    end

    // stage 2: quotient estimate and strand base
    always_comb
    begin
        prod_q  = (AbsW+DivW)'(abs1_reg) * (AbsW+DivW)'(cfg.recip);
        len_s   = $signed({1'b0, cfg.strand_len});
        prod_sl = strand1_reg * len_s;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            qest2_reg <= prod_q[RecipShift +: AbsW];
            psl2_reg  <= prod_sl;
            abs2_reg  <= abs1_reg;
            neg2_reg  <= neg1_reg;
            a0_2_reg  <= a0_1_reg;
            b2_reg    <= b1_reg;
            rb2_reg   <= rb1_reg;
        end
    end

    // stage 3: quotient times s, both candidate offsets
    always_comb
    begin
        prod_qs = (AbsW+StrandsW)'(qest2_reg) * (AbsW+StrandsW)'(cfg.strands);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            qs3_reg   <= prod_qs[AbsW-1:0];
            abs3_reg  <= abs2_reg;
            neg3_reg  <= neg2_reg;
            a0_3_reg  <= a0_2_reg;
            sumf3_reg <= psl2_reg + SumW'(b2_reg);
            sumr3_reg <= psl2_reg + SumW'(rb2_reg);
        end
    end

    // stage 4: remainder parity and strand direction
    always_comb
    begin
        diff    = abs3_reg - qs3_reg;
        rem_est = diff[RemW-1:0];
        rem_odd = (rem_est >= RemW'(cfg.strands)) ? (rem_est[0] ^ cfg.strands[0])
                                                  : rem_est[0];
        if (vert)
        begin
            one_test = (cfg.corner == CORNER_TL) || (cfg.corner == CORNER_TR);
        end
        else
        begin
            one_test = (cfg.corner == CORNER_BR) || (cfg.corner == CORNER_TR);
        end
        if (!cfg.strands[0])
        begin
            // even strand count: parity of the raw strand coordinate
            if (vert)
            begin
                unique case (cfg.corner)
                    CORNER_BL, CORNER_TR: fwd = !a0_3_reg;
                    CORNER_BR, CORNER_TL: fwd = a0_3_reg;
                    default:              fwd = !a0_3_reg;
                endcase
            end
            else
            begin
                unique case (cfg.corner)
                    CORNER_BL, CORNER_TL: fwd = !a0_3_reg;
                    CORNER_BR, CORNER_TR: fwd = a0_3_reg;
                    default:              fwd = !a0_3_reg;
                endcase
            end
        end
        else if (one_test)
        begin
            // a negative remainder is never equal to one
            fwd = !neg3_reg && rem_odd;
        end
        else
        begin
            fwd = !rem_odd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            sum4_reg <= fwd ? sumf3_reg : sumr3_reg;
        end
    end

    // stage 5: channel offset, span check, output register
    always_comb
    begin
        off     = (OffW'(sum4_reg) <<< 1) + OffW'(sum4_reg);
        in_span = !sum4_reg[SumW-1] && (off[OffW-2:0] < (OffW-1)'(cfg.span));
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            addr5_reg <= in_span ? (AddrW'(cfg.start) + off[AddrW-1:0]) : AddrW'(cfg.start);
            oor5_reg  <= !in_span;
        end
    end

    assign result.valid           = v5_reg;
    assign result.channel_address = addr5_reg;
    assign result.out_of_range    = oor5_reg;

endmodule

// ===== test/smcm_map_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard of the serpentine matrix channel mapper: mirrors the register writes,
// predicts the address of every accepted coordinate and checks each result against it.
// Depends on smcm_pkg and the channel interfaces of hdl/smcm_if.sv.
module smcm_map_checker import smcm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    smcm_coord_if               coord,
    smcm_result_if              result,
    output int                  fail_count,
    output int                  pending
);

    // channels per pixel
    localparam longint PixChannels = 3;

    typedef struct packed {
        logic [AddrW-1:0] channel_address;
        logic             out_of_range;
    } pixel_addr_t;

    // mirrored registers
    logic                orientation;
    corner_t             corner;
    logic [StringsW-1:0] string_count;
    logic [StrandsW-1:0] strands;
    logic [NodesW-1:0]   nodes_per_string;
    logic [ChanW-1:0]    start_channel;

    // addresses still owed by the block, oldest first
    pixel_addr_t addr_q[$];

    // address of one pixel under the mirrored registers, in exact signed arithmetic
    function automatic pixel_addr_t map_pixel_address(input logic [CoordW-1:0] px,
                                                      input logic [CoordW-1:0] py);
        longint x, y, s, strings, nodes, start, span;
        longint w, h, strand, len, along, loc, rem;
        logic far_side, fwd;
        pixel_addr_t r;
        x = longint'(px);
        y = longint'(py);
        s = (strands == '0) ? 1 : longint'(strands);
        strings = longint'(string_count);
        nodes = longint'(nodes_per_string);
        start = longint'(start_channel);
        span = nodes * strings * PixChannels;
        far_side = (corner == CORNER_BR) || (corner == CORNER_TR);
        if (orientation)
        begin
            // vertical strands: one strand per column
            w = strings * s;
            h = nodes / s;
            strand = far_side ? (w - x - 1) : x;
            len = h;
            rem = (strand % s) % 2;
            if (s % 2 == 0)
                fwd = ((corner == CORNER_BL) || (corner == CORNER_TR)) ?
                      (x % 2 == 0) : (x % 2 != 0);
            else if ((corner == CORNER_BL) || (corner == CORNER_BR))
                fwd = (rem == 0);
            else
                fwd = (rem == 1);
            along = fwd ? y : (h - y - 1);
        end
        else
        begin
            // horizontal strands: one strand per row
            w = nodes / s;
            h = strings * s;
            strand = ((corner == CORNER_TL) || (corner == CORNER_TR)) ? (h - y - 1) : y;
            len = w;
            rem = (strand % s) % 2;
            if (s % 2 == 0)
                fwd = far_side ? (y % 2 != 0) : (y % 2 == 0);
            else if (far_side)
                fwd = (rem == 1);
            else
                fwd = (rem == 0);
            along = fwd ? x : (w - x - 1);
        end
        loc = start + strand * len * PixChannels + along * PixChannels;
        // outside the channel span the start channel comes back flagged
        if (loc < start || loc >= start + span)
        begin
            r.channel_address = AddrW'(start);
            r.out_of_range = 1'b1;
        end
        else
        begin
            r.channel_address = AddrW'(loc);
            r.out_of_range = 1'b0;
        end
        return r;
    endfunction

    // register mirror, prediction and comparison
    always @(posedge clk or negedge rst_n)
    begin
        pixel_addr_t due;
        if (!rst_n)
        begin
            orientation      <= ResetOrientation;
            corner           <= ResetCorner;
            string_count     <= ResetStrings;
            strands          <= ResetStrands;
            nodes_per_string <= ResetNodes;
            start_channel    <= ResetStart;
            addr_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            // register writes, unknown indexes ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIENTATION:   orientation      <= cfg_data[0];
                    REG_START_CORNER:  corner           <= corner_t'(cfg_data[1:0]);
                    REG_STRING_COUNT:  string_count     <= cfg_data[StringsW-1:0];
                    REG_STRANDS:       strands          <= cfg_data[StrandsW-1:0];
                    REG_NODES:         nodes_per_string <= cfg_data[NodesW-1:0];
                    REG_START_CHANNEL: start_channel    <= cfg_data[ChanW-1:0];
                    default: ;
                endcase
            end

            // retire the oldest expected address
            if (result.valid && result.ready)
            begin
                if (addr_q.size() == 0)
                begin
                    $error("unexpected item: channel_address %0d, out_of_range %0b",
                           result.channel_address, result.out_of_range);
                    fail_count++;
                end
                else
                begin
                    due = addr_q.pop_front();
                    if (result.channel_address !== due.channel_address)
                    begin
                        $error("channel_address: expected %0d, actual %0d",
                               due.channel_address, result.channel_address);
                        fail_count++;
                    end
                    if (result.out_of_range !== due.out_of_range)
                    begin
                        $error("out_of_range: expected %0b, actual %0b",
                               due.out_of_range, result.out_of_range);
                        fail_count++;
                    end
                end
            end

            // predict each accepted coordinate
            if (coord.valid && coord.ready)
                addr_q.push_back(map_pixel_address(coord.pos_x, coord.pos_y));

            pending <= addr_q.size();
        end
    end

endmodule

// ===== test/serpentine_matrix_channel_map_core_tb.sv =====
`timescale 1ns / 100ps
// Top of the mapper testbench: clock, reset, register loads, coordinate stimulus,
// receiver stalls, watchdog and verdict. Depends on smcm_pkg, hdl/smcm_if.sv,
// the mapper core and smcm_map_checker.
module serpentine_matrix_channel_map_core_tb;
    import smcm_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 20;
    localparam int ItemTarget    = 1700;
    localparam int CoordMax      = (1 << CoordW) - 1;
    localparam int StartMax      = (1 << ChanW) - 1;
    localparam int StringsMax    = (1 << StringsW) - 1;
    localparam int StrandsMax    = (1 << StrandsW) - 1;
    localparam int NodesMax      = (1 << NodesW) - 1;

    localparam logic OrientHorizontal = 1'b0;
    localparam logic OrientVertical   = 1'b1;
    localparam logic [CfgIdxW-1:0] RegFirstUnused = CfgIdxW'(REG_START_CHANNEL + 1);

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } rx_pattern_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    smcm_coord_if  coord();
    smcm_result_if result();

    int          fail_count;
    int          pending;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int          map_w       = 1;
    int          map_h       = 1;
    rx_pattern_t rx_pattern  = RX_OPEN;
    int          rx_left     = 0;

    always #5 clk = ~clk;

    serpentine_matrix_channel_map_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coord     (coord),
        .result    (result)
    );

    smcm_map_checker map_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coord      (coord),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: a random stall pattern, picked anew whenever its countdown runs out
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 256);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_pattern)
            RX_OPEN:     result.ready <= 1'b1;
            RX_RANDOM:   result.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: result.ready <= (rx_left % 6) < 4;
            default:     result.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (coord.valid && coord.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("** serpentine_matrix_channel_map_core: FAILED **");
            $finish;
        end
    end

    // offer one coordinate and hold it until accepted
    task automatic send_coord(input int x, input int y);
        coord.valid <= 1'b1;
        coord.pos_x <= CoordW'(x);
        coord.pos_y <= CoordW'(y);
        do @(posedge clk); while (!coord.ready);
        items_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        coord.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop sending until every expected address has come back
    task automatic wait_all_results();
        coord.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // one register write, random junk above the register width
    task automatic put_reg(input logic [CfgIdxW-1:0] idx, input int value, input int width);
        logic [CfgDataW-1:0] junk;
        junk = CfgDataW'($urandom());
        cfg_we <= 1'b1;
        cfg_index <= idx;
        if (width >= CfgDataW)
            cfg_data <= CfgDataW'(value);
        else
            cfg_data <= (junk << width) | CfgDataW'(value);
        @(posedge clk);
    endtask

    // load a full mapping once the block has gone idle
    task automatic load_map(input logic orient, input corner_t corner_sel, input int strings,
                            input int strands, input int nodes, input int start);
        int s_eff;
        wait_all_results();
        put_reg(REG_ORIENTATION, orient, 1);
        put_reg(REG_START_CORNER, corner_sel, 2);
        put_reg(REG_STRING_COUNT, strings, StringsW);
        put_reg(REG_STRANDS, strands, StrandsW);
        put_reg(REG_NODES, nodes, NodesW);
        put_reg(REG_START_CHANNEL, start, ChanW);
        put_reg(CfgIdxW'(RegFirstUnused + $urandom_range(0, 1)), $urandom(), CfgDataW);
        cfg_we <= 1'b0;
        // matrix extent, used to aim the coordinates
        s_eff = (strands == 0) ? 1 : strands;
        if (orient == OrientVertical)
        begin
            map_w = strings * s_eff;
            map_h = nodes / s_eff;
        end
        else
        begin
            map_w = nodes / s_eff;
            map_h = strings * s_eff;
        end
    endtask

    // mostly inside the matrix or just past it, sometimes anywhere
    function automatic int pick_coord(input int extent);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, CoordMax);
        return $urandom_range(0, (extent + 1 > CoordMax) ? CoordMax : extent + 1);
    endfunction

    initial
    begin
        logic    orient;
        corner_t corner_sel;
        int      strings, strands, nodes, start, s_eff, phase_left, burst, gap;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_ORIENTATION;
        cfg_data     <= '0;
        coord.valid  <= 1'b0;
        coord.pos_x  <= '0;
        coord.pos_y  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset mapping: one horizontal strand of fifty pixels
        send_coord(0, 0);
        send_coord(49, 0);
        send_coord(0, 1);
        send_coord(CoordMax, CoordMax);

        // even strand count, vertical, far corner, strand index going negative
        load_map(OrientVertical, CORNER_BR, 2, 2, 8, 100);
        send_coord(0, 0);
        send_coord(1, 3);
        send_coord(3, 0);
        send_coord(5, 1);

        // odd strand count, vertical, top right, negative strand index
        load_map(OrientVertical, CORNER_TR, 2, 3, 9, 7);
        send_coord(0, 0);
        send_coord(1, 2);
        send_coord(4, 1);
        send_coord(8, 0);

        // zero strands taken as one, horizontal from the top left
        load_map(OrientHorizontal, CORNER_TL, 3, 0, 5, 40);
        send_coord(0, 0);
        send_coord(4, 2);
        send_coord(2, 5);

        // largest matrix with the highest start channel
        load_map(OrientVertical, CORNER_BR, StringsMax, StrandsMax, NodesMax, StartMax);
        send_coord(0, 0);
        send_coord(CoordMax, CoordMax);
        send_coord(2047, 15);

        // empty matrix: every address out of the span
        load_map(OrientHorizontal, CORNER_TR, 0, 1, 0, 0);
        send_coord(0, 0);
        send_coord(CoordMax, CoordMax);

        // random mappings with bursts of coordinates
        while (items_sent < ItemTarget)
        begin
            orient = 1'($urandom_range(0, 1));
            corner_sel = corner_t'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       strands = 0;
                1:       strands = StrandsMax;
                default: strands = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       strings = 0;
                1:       strings = StringsMax;
                default: strings = $urandom_range(1, 8);
            endcase
            s_eff = (strands == 0) ? 1 : strands;
            case ($urandom_range(0, 9))
                0:       nodes = 0;
                1:       nodes = NodesMax;
                default: nodes = s_eff * $urandom_range(1, 16) + $urandom_range(0, s_eff - 1);
            endcase
            if (nodes > NodesMax)
                nodes = NodesMax;
            case ($urandom_range(0, 9))
                0:       start = 0;
                1:       start = StartMax;
                default: start = $urandom_range(0, StartMax);
            endcase
            load_map(orient, corner_sel, strings, strands, nodes, start);

            phase_left = $urandom_range(20, 60);
            while (phase_left > 0)
            begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
                while (burst > 0 && phase_left > 0)
                begin
                    send_coord(pick_coord(map_w), pick_coord(map_h));
                    burst--;
                    phase_left--;
                end
                if ($urandom_range(0, 9) == 0)
                    wait_all_results();
                else
                begin
                    gap = $urandom_range(0, 10);
                    if (gap > 0)
                        idle_sender(gap);
                end
            end
        end

        wait_all_results();
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("** serpentine_matrix_channel_map_core: PASSED **");
        else
            $display("** serpentine_matrix_channel_map_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/smcm_pkg.sv
hdl/smcm_if.sv
hdl/smcm_div.sv
hdl/smcm_cfg.sv
hdl/smcm_pipe.sv
hdl/serpentine_matrix_channel_map_core.sv
test/smcm_map_checker.sv
test/serpentine_matrix_channel_map_core_tb.sv
